@@ sv/relative_humidity_from_dew_point_core_macros.svh @@
// Assertion helpers used by the top RTL file of the humidity core.
`ifndef RELATIVE_HUMIDITY_FROM_DEW_POINT_CORE_MACROS_SVH
`define RELATIVE_HUMIDITY_FROM_DEW_POINT_CORE_MACROS_SVH

`ifndef SYNTHESIS
`define RHDP_ASSERT_IMPL(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("rhdp assertion failed");
`define RHDP_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("rhdp assertion failed");
`else
`define RHDP_ASSERT_IMPL(lbl, clk, rst, ante, cons)
`define RHDP_ASSERT_NEXT(lbl, clk, rst, ante, cons)
`endif

`endif

@@ sv/rhdp_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
package rhdp_pkg;

  localparam int TEMP_FRAC_BITS_DEF = 6;
  localparam int K_TETENS_Q16 = 1131807;
  localparam int K_W = 21;
  localparam int ARG_LIM_Q16 = 8388608;
  localparam int LN2_Q16 = 45426;
  localparam int RH_MAX = 2000;
  localparam int SERIES_TERMS = 12;
  localparam int QBITS = 24;
  localparam int TERM_W = 31;
  localparam int SUM_W = 32;
  localparam int R_W = 16;
  localparam int K_IDX_W = 4;

  typedef enum logic [1:0] {
    SEL_CALC,
    SEL_ZERO,
    SEL_MAX
  } sel_t;

  typedef struct packed {
    logic inv;
    logic neg;
    logic zero;
    logic ovf;
  } div_flags_t;

  typedef struct packed {
    logic inv;
    sel_t sel;
    logic [K_IDX_W-1:0] k;
  } side_t;

endpackage
`default_nettype wire

@@ sv/rhdp_div_cell.sv @@
`timescale 1ns / 1ps
`default_nettype none
module rhdp_div_cell #(
  parameter int DW = 17
) (
  input  logic                      clk,
  input  logic                      en,
  input  logic [DW-1:0]             rem_i,
  input  logic [rhdp_pkg::QBITS-1:0] low_i,
  input  logic [rhdp_pkg::QBITS-1:0] q_i,
  input  logic [DW-1:0]             d_i,
  input  rhdp_pkg::div_flags_t      flags_i,
  output logic [DW-1:0]             rem_o,
  output logic [rhdp_pkg::QBITS-1:0] low_o,
  output logic [rhdp_pkg::QBITS-1:0] q_o,
  output logic [DW-1:0]             d_o,
  output rhdp_pkg::div_flags_t      flags_o
);

  logic [DW:0] t;
  logic        ge;

  always_comb begin
    t  = {rem_i, low_i[rhdp_pkg::QBITS-1]};
    ge = (t >= {1'b0, d_i});
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rem_o   <= ge ? DW'(t - {1'b0, d_i}) : DW'(t);
      low_o   <= {low_i[rhdp_pkg::QBITS-2:0], 1'b0};
      q_o     <= {q_i[rhdp_pkg::QBITS-2:0], ge};
      d_o     <= d_i;
      flags_o <= flags_i;
    end
  end

endmodule
`default_nettype wire

@@ sv/rhdp_term_cell.sv @@
`timescale 1ns / 1ps
`default_nettype none
module rhdp_term_cell #(
  parameter int STEP = 1
) (
  input  logic                        clk,
  input  logic                        en,
  input  logic [rhdp_pkg::TERM_W-1:0] term_i,
  input  logic [rhdp_pkg::SUM_W-1:0]  sum_i,
  input  logic [rhdp_pkg::R_W-1:0]    r_i,
  input  rhdp_pkg::side_t             side_i,
  output logic [rhdp_pkg::TERM_W-1:0] term_o,
  output logic [rhdp_pkg::SUM_W-1:0]  sum_o,
  output logic [rhdp_pkg::R_W-1:0]    r_o,
  output rhdp_pkg::side_t             side_o
);

  localparam int TW = rhdp_pkg::TERM_W;
  localparam int SW = rhdp_pkg::SUM_W;
  localparam int RW = rhdp_pkg::R_W;
  localparam int RECIP_W = 33;
  localparam logic [RECIP_W-1:0] RECIP = RECIP_W'((64'd1 << 32) / STEP);

  logic [TW-1:0]      p_a;
  logic [SW-1:0]      sum_a;
  logic [RW-1:0]      r_a;
  rhdp_pkg::side_t    side_a;
  logic [TW-1:0]      p_b;
  logic [TW-1:0]      q0_b;
  logic [SW-1:0]      sum_b;
  logic [RW-1:0]      r_b;
  rhdp_pkg::side_t    side_b;
  logic [TW+RW-1:0]   prod;
  logic [TW+RECIP_W-1:0] big;
  logic [TW-1:0]      rem;
  logic [TW-1:0]      q;

  always_comb begin
    prod = (TW+RW)'(term_i) * (TW+RW)'(r_i);
    big  = (TW+RECIP_W)'(p_a) * (TW+RECIP_W)'(RECIP);
    rem  = p_b - TW'(q0_b * TW'(STEP));
    q    = (rem >= TW'(STEP)) ? q0_b + TW'(1) : q0_b;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p_a    <= TW'(prod >> 16);
      sum_a  <= sum_i;
      r_a    <= r_i;
      side_a <= side_i;
      p_b    <= p_a;
      q0_b   <= TW'(big >> 32);
      sum_b  <= sum_a;
      r_b    <= r_a;
      side_b <= side_a;
      term_o <= q;
      sum_o  <= sum_b + SW'(q);
      r_o    <= r_b;
      side_o <= side_b;
    end
  end

endmodule
`default_nettype wire

@@ sv/relative_humidity_from_dew_point_core.sv @@
// Relative humidity core, Tetens form.
// Input channel: in_valid, in_stall, dew_point_k and air_temp_k, signed Kelvin with
// TEMP_FRAC_BITS fraction bits. Output channel: out_valid, out_stall, rh_tenths
// (0 to 2000, tenths of a percent) and invalid.
// A beat is taken on an edge where valid is high and stall is low.
// The pipeline accepts one beat every cycle unless the receiver stalls, and is built of
// three setup stages, one divider cell per quotient bit (24 cells, both pressures
// side by side), two reduction stages, three stages per series term (12 cells)
// and two output stages.
// When the receiver stalls while a result waits, the whole pipeline holds and
// in_stall is raised in the same cycle; nothing is dropped.
// A negative input gives invalid high and rh_tenths zero.
// Reset clears all valid bits; the block takes beats from the first cycle after it.
`timescale 1ns / 1ps
`default_nettype none
`include "relative_humidity_from_dew_point_core_macros.svh"
module relative_humidity_from_dew_point_core #(
  parameter int TEMP_FRAC_BITS = rhdp_pkg::TEMP_FRAC_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic signed [15:0] dew_point_k,
  input  logic signed [15:0] air_temp_k,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [10:0]        rh_tenths,
  output logic               invalid
);

  localparam int QB = rhdp_pkg::QBITS;
  localparam int NT = rhdp_pkg::SERIES_TERMS;
  localparam int OFF273 = 273 << TEMP_FRAC_BITS;
  localparam int OFF36 = 36 << TEMP_FRAC_BITS;
  localparam int NUMW = $clog2(OFF273 + 32769) + 1;
  localparam int NMW = NUMW - 1;
  localparam int MAGW = rhdp_pkg::K_W + NMW;
  localparam int NW = MAGW + 2;
  localparam int DW = NUMW;
  localparam int HW = NW - QB;
  localparam int CW = (HW > DW) ? HW : DW;
  localparam int ARGW = 26;
  localparam int VW = 42;
  localparam int NSTG = 3 + QB + 2 + 3 * NT + 2;
  localparam int TW = rhdp_pkg::TERM_W;
  localparam int SW = rhdp_pkg::SUM_W;
  localparam int RW = rhdp_pkg::R_W;
  localparam int KW = rhdp_pkg::K_IDX_W;
  localparam logic signed [ARGW-1:0] LIM = ARGW'(rhdp_pkg::ARG_LIM_Q16);
  localparam logic signed [ARGW-1:0] LN2 = ARGW'(rhdp_pkg::LN2_Q16);
  localparam logic signed [ARGW-1:0] LOW = -$signed(ARGW'(11 * rhdp_pkg::LN2_Q16));

  logic [NSTG-1:0] vld;
  logic            adv;

  logic [NMW-1:0]  p1_nmag [2];
  logic [NMW-1:0]  p1_dm   [2];
  logic            p1_neg  [2];
  logic            p1_zero [2];
  logic            p1_inv;
  logic [MAGW-1:0] p2_mag  [2];
  logic [NMW-1:0]  p2_dm   [2];
  logic            p2_neg  [2];
  logic            p2_zero [2];
  logic            p2_inv;

  logic [DW-1:0]   dv_rem   [2][QB+1];
  logic [QB-1:0]   dv_low   [2][QB+1];
  logic [QB-1:0]   dv_q     [2][QB+1];
  logic [DW-1:0]   dv_d     [2][QB+1];
  rhdp_pkg::div_flags_t dv_flags [2][QB+1];

  logic signed [ARGW-1:0] r1_arg [2];
  logic                   r1_inv;

  logic [TW-1:0]   sr_term [NT+1];
  logic [SW-1:0]   sr_sum  [NT+1];
  logic [RW-1:0]   sr_r    [NT+1];
  rhdp_pkg::side_t sr_side [NT+1];

  logic [VW-1:0]   o1_v;
  rhdp_pkg::side_t o1_side;

  assign adv       = !(vld[NSTG-1] && out_stall);
  assign in_stall  = !adv;
  assign out_valid = vld[NSTG-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (adv) begin
      vld <= {vld[NSTG-2:0], in_valid};
    end
  end

  function automatic logic signed [ARGW-1:0] lane_arg(input logic [QB-1:0] q,
                                                     input rhdp_pkg::div_flags_t f);
    logic [QB-1:0] qm;
    logic signed [ARGW-1:0] a;
    qm = (f.ovf || q > QB'(rhdp_pkg::ARG_LIM_Q16)) ? QB'(rhdp_pkg::ARG_LIM_Q16) : q;
    a  = $signed(ARGW'(qm));
    if (f.zero) begin
      return -LIM;
    end
    return f.neg ? -a : a;
  endfunction

  always_ff @(posedge clk) begin
    logic signed [NUMW-1:0] xe;
    logic signed [NUMW-1:0] num;
    logic signed [NUMW-1:0] den;
    if (adv) begin
      p1_inv <= dew_point_k[15] || air_temp_k[15];
      for (int l = 0; l < 2; l++) begin
        xe  = (l == 0) ? NUMW'(dew_point_k) : NUMW'(air_temp_k);
        num = xe - $signed(NUMW'(OFF273));
        den = xe - $signed(NUMW'(OFF36));
        p1_nmag[l] <= num[NUMW-1] ? NMW'(-num) : NMW'(num);
        p1_dm[l]   <= den[NUMW-1] ? NMW'(-den) : NMW'(den);
        p1_neg[l]  <= num[NUMW-1] ^ den[NUMW-1];
        p1_zero[l] <= (den == '0);
      end
      p2_inv <= p1_inv;
      for (int l = 0; l < 2; l++) begin
        p2_mag[l]  <= MAGW'(p1_nmag[l]) * MAGW'(rhdp_pkg::K_TETENS_Q16);
        p2_dm[l]   <= p1_dm[l];
        p2_neg[l]  <= p1_neg[l];
        p2_zero[l] <= p1_zero[l];
      end
    end
  end

  for (genvar l = 0; l < 2; l++) begin : g_setup
    logic [NW-1:0] nn;
    logic [HW-1:0] hi;

    assign nn = {1'b0, p2_mag[l], 1'b0} + NW'(p2_dm[l]);
    assign hi = nn[NW-1:QB];

    always_ff @(posedge clk) begin
      if (adv) begin
        dv_rem[l][0]        <= DW'(hi);
        dv_low[l][0]        <= nn[QB-1:0];
        dv_q[l][0]          <= '0;
        dv_d[l][0]          <= {p2_dm[l], 1'b0};
        dv_flags[l][0].inv  <= p2_inv;
        dv_flags[l][0].neg  <= p2_neg[l];
        dv_flags[l][0].zero <= p2_zero[l];
        dv_flags[l][0].ovf  <= CW'(hi) >= CW'({p2_dm[l], 1'b0});
      end
    end
  end

  for (genvar l = 0; l < 2; l++) begin : g_lane
    for (genvar s = 0; s < QB; s++) begin : g_div
      rhdp_div_cell #(.DW(DW)) u_cell (
        .clk     (clk),
        .en      (adv),
        .rem_i   (dv_rem[l][s]),
        .low_i   (dv_low[l][s]),
        .q_i     (dv_q[l][s]),
        .d_i     (dv_d[l][s]),
        .flags_i (dv_flags[l][s]),
        .rem_o   (dv_rem[l][s+1]),
        .low_o   (dv_low[l][s+1]),
        .q_o     (dv_q[l][s+1]),
        .d_o     (dv_d[l][s+1]),
        .flags_o (dv_flags[l][s+1])
      );
    end
  end

  always_ff @(posedge clk) begin
    logic signed [ARGW-1:0] diff;
    logic [KW-1:0]          kk;
    if (adv) begin
      r1_arg[0] <= lane_arg(dv_q[0][QB], dv_flags[0][QB]);
      r1_arg[1] <= lane_arg(dv_q[1][QB], dv_flags[1][QB]);
      r1_inv    <= dv_flags[0][QB].inv;

      diff = r1_arg[0] - r1_arg[1];
      kk   = '0;
      for (int j = 11; j >= 0; j--) begin
        if (diff + $signed(ARGW'(j * rhdp_pkg::LN2_Q16)) >= 0) begin
          kk = KW'(j);
        end
      end
      sr_side[0].inv <= r1_inv;
      sr_side[0].k   <= kk;
      if (r1_inv || r1_arg[0] == -LIM) begin
        sr_side[0].sel <= rhdp_pkg::SEL_ZERO;
      end else if (r1_arg[1] == -LIM || diff >= LN2) begin
        sr_side[0].sel <= rhdp_pkg::SEL_MAX;
      end else if (diff < LOW) begin
        sr_side[0].sel <= rhdp_pkg::SEL_ZERO;
      end else begin
        sr_side[0].sel <= rhdp_pkg::SEL_CALC;
      end
      sr_r[0]    <= RW'(diff + $signed(ARGW'(kk * rhdp_pkg::LN2_Q16)));
      sr_term[0] <= TW'(1) << 30;
      sr_sum[0]  <= SW'(1) << 30;
    end
  end

  for (genvar i = 0; i < NT; i++) begin : g_term
    rhdp_term_cell #(.STEP(i + 1)) u_cell (
      .clk    (clk),
      .en     (adv),
      .term_i (sr_term[i]),
      .sum_i  (sr_sum[i]),
      .r_i    (sr_r[i]),
      .side_i (sr_side[i]),
      .term_o (sr_term[i+1]),
      .sum_o  (sr_sum[i+1]),
      .r_o    (sr_r[i+1]),
      .side_o (sr_side[i+1])
    );
  end

  always_ff @(posedge clk) begin
    logic [VW:0] rnd;
    logic [VW:0] sh;
    if (adv) begin
      o1_v    <= VW'(sr_sum[NT]) * VW'(1000);
      o1_side <= sr_side[NT];

      rnd = (VW+1)'(o1_v) + ((VW+1)'(1) << (6'd29 + 6'(o1_side.k)));
      sh  = rnd >> (6'd30 + 6'(o1_side.k));
      invalid <= o1_side.inv;
      case (o1_side.sel)
        rhdp_pkg::SEL_ZERO: rh_tenths <= '0;
        rhdp_pkg::SEL_MAX:  rh_tenths <= 11'(rhdp_pkg::RH_MAX);
        default: begin
          rh_tenths <= (sh > (VW+1)'(rhdp_pkg::RH_MAX)) ? 11'(rhdp_pkg::RH_MAX) : 11'(sh);
        end
      endcase
    end
  end

  `RHDP_ASSERT_IMPL(a_rh_range, clk, rst, out_valid, rh_tenths <= 11'(rhdp_pkg::RH_MAX))
  `RHDP_ASSERT_IMPL(a_inv_zero, clk, rst, out_valid && invalid, rh_tenths == '0)
  `RHDP_ASSERT_IMPL(a_stall_src, clk, rst, in_stall, out_valid && out_stall)
  `RHDP_ASSERT_NEXT(a_hold, clk, rst, in_stall, $stable(vld))

endmodule
`default_nettype wire

@@ bench/relative_humidity_from_dew_point_core_test.sv @@
`timescale 1ns / 1ps
module relative_humidity_from_dew_point_core_test;

  localparam int FRAC = rhdp_pkg::TEMP_FRAC_BITS_DEF;
  localparam int LATENCY = 67;
  localparam int IDLE_LIMIT = 20000;

  typedef struct {
    logic signed [15:0] dew;
    logic signed [15:0] temp;
  } reading_t;

  typedef struct {
    logic [10:0] rh;
    logic        inv;
  } humidity_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  logic signed [15:0] dew_point_k = '0;
  logic signed [15:0] air_temp_k = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [10:0] rh_tenths;
  logic invalid;
  logic in_stall_q = 1'b0;

  reading_t  pending_readings[$];
  humidity_t expected_humidity[$];
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int hold_off_cycles = 0;
  int mismatches = 0;
  int idle_cycles = 0;
  bit stimulus_done = 1'b0;

  relative_humidity_from_dew_point_core i_dut (.*);

  always #6 clk = ~clk;

  function automatic longint tetens_exponent(longint x);
    longint num, den, prod, mag, dm, q;
    num = x - (longint'(273) << FRAC);
    den = x - (longint'(36) << FRAC);
    if (den == 0) return -longint'(rhdp_pkg::ARG_LIM_Q16);
    prod = longint'(rhdp_pkg::K_TETENS_Q16) * num;
    mag = prod < 0 ? -prod : prod;
    dm = den < 0 ? -den : den;
    q = (2 * mag + dm) / (2 * dm);
    if (q > rhdp_pkg::ARG_LIM_Q16) q = rhdp_pkg::ARG_LIM_Q16;
    return ((prod < 0) != (den < 0)) ? -q : q;
  endfunction

  function automatic longint pressure_ratio_tenths(longint diff);
    longint n, r;
    logic [63:0] r30, term, sum, v, rh;
    int s;
    if (diff >= 0) n = diff / rhdp_pkg::LN2_Q16;
    else n = -((-diff + rhdp_pkg::LN2_Q16 - 1) / rhdp_pkg::LN2_Q16);
    r = diff - n * rhdp_pkg::LN2_Q16;
    if (n >= 1) return rhdp_pkg::RH_MAX;
    if (n <= -12) return 0;
    r30 = 64'(r) << 14;
    term = 64'd1 << 30;
    sum = term;
    for (int i = 1; i <= rhdp_pkg::SERIES_TERMS; i++) begin
      term = ((term * r30) >> 30) / i;
      sum += term;
    end
    v = sum * 1000;
    s = 30 - int'(n);
    rh = (v + (64'd1 << (s - 1))) >> s;
    if (rh > rhdp_pkg::RH_MAX) rh = rhdp_pkg::RH_MAX;
    return rh;
  endfunction

  function automatic humidity_t predict_humidity(reading_t rd);
    humidity_t h;
    longint ad, at;
    h.inv = 1'b0;
    h.rh = '0;
    if (rd.dew < 0 || rd.temp < 0) begin
      h.inv = 1'b1;
      return h;
    end
    ad = tetens_exponent(rd.dew);
    at = tetens_exponent(rd.temp);
    if (ad == -longint'(rhdp_pkg::ARG_LIM_Q16)) h.rh = 0;
    else if (at == -longint'(rhdp_pkg::ARG_LIM_Q16)) h.rh = rhdp_pkg::RH_MAX;
    else h.rh = 11'(pressure_ratio_tenths(ad - at));
    return h;
  endfunction

  task automatic queue_reading(int dew, int temp);
    reading_t rd;
    rd.dew = 16'(dew);
    rd.temp = 16'(temp);
    pending_readings.push_back(rd);
  endtask

  function automatic int random_kelvin();
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 70) return $urandom_range(200 << FRAC, 330 << FRAC);
    if (pick < 80) return $urandom_range(0, 32767);
    if (pick < 88) return $urandom_range(30 << FRAC, 42 << FRAC);
    return 16'($urandom);
  endfunction

  task automatic queue_random(int count);
    int t, d;
    for (int i = 0; i < count; i++) begin
      t = random_kelvin();
      if ($urandom_range(0, 3) != 0 && t > 0 && t < 32767)
        d = t - $urandom_range(0, 40 << FRAC);
      else
        d = random_kelvin();
      queue_reading(d, t);
    end
  endtask

  task automatic wait_drained();
    while (pending_readings.size() != 0 || in_valid || expected_humidity.size() != 0)
      @(posedge clk);
  endtask

  always @(negedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else if (hold_off_cycles > 0) begin
      out_stall <= 1'b1;
      hold_off_cycles <= hold_off_cycles - 1;
    end else begin
      out_stall <= ($urandom_range(0, 99) < recv_idle_pct);
    end
  end

  always @(negedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (!in_valid || !in_stall_q) begin
        if (pending_readings.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
          in_valid <= 1'b1;
          dew_point_k <= pending_readings[0].dew;
          air_temp_k <= pending_readings[0].temp;
          void'(pending_readings.pop_front());
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    in_stall_q <= in_stall;
    if (in_valid && !in_stall && !rst)
      expected_humidity.push_back(predict_humidity('{dew_point_k, air_temp_k}));
  end

  always @(posedge clk) begin
    humidity_t exp_h;
    if (!rst && out_valid && !out_stall) begin
      if (expected_humidity.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("Unexpected beat: rh=%0d invalid=%0b", rh_tenths, invalid);
      end else begin
        exp_h = expected_humidity.pop_front();
        if (exp_h.rh !== rh_tenths || exp_h.inv !== invalid) begin
          mismatches++;
          if (mismatches <= 10)
            $display("Mismatch: expected rh=%0d invalid=%0b, got rh=%0d invalid=%0b",
                     exp_h.rh, exp_h.inv, rh_tenths, invalid);
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > IDLE_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  initial begin
    repeat (8) @(posedge clk);
    @(negedge clk) rst = 1'b0;
    queue_reading(-1, 300 << FRAC);
    queue_reading(290 << FRAC, -32768);
    queue_reading(-32768, -1);
    queue_reading(0, 0);
    queue_reading(32767, 32767);
    queue_reading(36 << FRAC, 300 << FRAC);
    queue_reading(280 << FRAC, 36 << FRAC);
    queue_reading(36 << FRAC, 36 << FRAC);
    queue_reading(273 << FRAC, 273 << FRAC);
    queue_reading(300 << FRAC, 290 << FRAC);
    queue_reading(250 << FRAC, 320 << FRAC);
    queue_reading(200 << FRAC, 330 << FRAC);
    queue_reading(37 << FRAC, 300 << FRAC);
    queue_reading(35 << FRAC, 300 << FRAC);
    queue_reading(300 << FRAC, 37 << FRAC);
    queue_reading(300 << FRAC, 35 << FRAC);
    queue_reading(1, 32767);
    queue_reading(32767, 1);
    queue_reading(21845, 10922);
    queue_reading(10922, 21845);
    queue_reading(290 << FRAC, (290 << FRAC) + 1);
    wait_drained();
    send_idle_pct = 26;
    recv_idle_pct = 79;
    queue_random(500);
    wait_drained();
    hold_off_cycles = 300;
    send_idle_pct = 0;
    queue_random(150);
    wait_drained();
    send_idle_pct = 79;
    recv_idle_pct = 26;
    queue_random(450);
    wait_drained();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    queue_random(450);
    wait_drained();
    repeat (LATENCY + 10) @(posedge clk);
    if (mismatches == 0) $display("Testbench completed without errors");
    else $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
